// ===== design/vsag_pkg.sv =====
package vsag_pkg;

  // Defaults for the top-level parameters.
  localparam int COORD_BITS_DEF = 16;
  localparam int ADDR_BITS_DEF  = 32;
  localparam int MAX_SUBDIV_DEF = 16;

  // Fixed widths of the interface fields.
  localparam int FIELD_W  = 16;
  localparam int REG_W    = 48;
  localparam int SUBDIV_W = 5;
  localparam int DEST_W   = 32;
  localparam int SAMPLE_W = 64;
  localparam int IDX_W    = 3;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_ORDER_MODE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_VOLUME_DIMS  = 3'd1;
  localparam logic [IDX_W-1:0] REG_SUBDIVISION  = 3'd2;
  localparam logic [IDX_W-1:0] REG_LOCAL_OFFSET = 3'd3;
  localparam logic [IDX_W-1:0] REG_LOCAL_DIMS   = 3'd4;

  typedef struct packed {
    logic                order_mode;
    logic [REG_W-1:0]    volume_dims;
    logic [SUBDIV_W-1:0] subdivision;
    logic [REG_W-1:0]    local_offset;
    logic [REG_W-1:0]    local_dims;
  } cfg_t;

  // One 16-bit component of a three-component register, axis 0 in the low bits.
  function automatic logic [FIELD_W-1:0] field16(input logic [REG_W-1:0] r,
                                                 input logic [1:0] axis);
    return r[FIELD_W*axis +: FIELD_W];
  endfunction

endpackage

// ===== design/vsag_fifo.sv =====
module vsag_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd,
  output logic [W-1:0] rd_data,
  output logic         empty
);
  localparam int DEPTH = 2;

  logic [W-1:0] mem [DEPTH];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         do_wr;
  logic         do_rd;

  assign full    = (count == 2'(DEPTH));
  assign empty   = (count == 2'd0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_wr && !do_rd) begin
        count <= count + 2'd1;
      end else if (do_rd && !do_wr) begin
        count <= count - 2'd1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(DEPTH)) else $error("queue count above depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (!rst && do_wr && !do_rd) |=> (count == $past(count) + 2'd1))
    else $error("queue count did not grow on a write");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (!rst && do_rd && !do_wr) |=> (count == $past(count) - 2'd1))
    else $error("queue count did not shrink on a read");
`endif

endmodule

// ===== design/vsag_front.sv =====
module vsag_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  vsag_pkg::cfg_t                  cfg,
  input  logic                            push,
  output logic                            full,
  input  logic [vsag_pkg::SAMPLE_W-1:0]   sample_bits,
  input  logic                            first_of_volume,
  output logic                            q_push,
  output logic [3*COORD_BITS+vsag_pkg::SAMPLE_W-1:0] q_data,
  input  logic                            q_full
);
  import vsag_pkg::*;

  localparam int CW = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;

  logic [COORD_BITS-1:0] coord [3];
  logic [COORD_BITS-1:0] cur [3];
  logic [COORD_BITS-1:0] coord_next [3];
  logic [COORD_BITS:0]   bx;
  logic [COORD_BITS:0]   by;
  logic [COORD_BITS:0]   bz;
  logic                  accept;

  // Returns {wrapped, new value} for one axis step.
  function automatic logic [COORD_BITS:0] bump(input logic [COORD_BITS-1:0] c,
                                               input logic [FIELD_W-1:0] ext);
    logic [COORD_BITS-1:0] n;
    logic                  wrap;
    n    = c + COORD_BITS'(1);
    wrap = (n == '0) || (CW'(n) >= CW'(ext));
    return wrap ? {1'b1, {COORD_BITS{1'b0}}} : {1'b0, n};
  endfunction

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_push = accept;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      cur[a] = first_of_volume ? '0 : coord[a];
    end
  end

  assign q_data = {cur[2], cur[1], cur[0], sample_bits};

  assign bx = bump(cur[0], field16(cfg.volume_dims, 2'd0));
  assign by = bump(cur[1], field16(cfg.volume_dims, 2'd1));
  assign bz = bump(cur[2], field16(cfg.volume_dims, 2'd2));

  // F order walks x fastest, C order walks z fastest; y sits in the middle.
  always_comb begin
    coord_next[0] = cur[0];
    coord_next[1] = cur[1];
    coord_next[2] = cur[2];
    if (cfg.order_mode) begin
      coord_next[0] = bx[COORD_BITS-1:0];
      if (bx[COORD_BITS]) begin
        coord_next[1] = by[COORD_BITS-1:0];
        if (by[COORD_BITS]) begin
          coord_next[2] = bz[COORD_BITS-1:0];
        end
      end
    end else begin
      coord_next[2] = bz[COORD_BITS-1:0];
      if (bz[COORD_BITS]) begin
        coord_next[1] = by[COORD_BITS-1:0];
        if (by[COORD_BITS]) begin
          coord_next[0] = bx[COORD_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        coord[a] <= '0;
      end
    end else if (accept) begin
      for (int a = 0; a < 3; a++) begin
        coord[a] <= coord_next[a];
      end
    end
  end

endmodule

// ===== design/vsag_back.sv =====
module vsag_back #(
  parameter int COORD_BITS = 16,
  parameter int ADDR_BITS  = 32,
  parameter int MAX_SUBDIV = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  vsag_pkg::cfg_t        cfg,
  input  logic                  in_empty,
  output logic                  in_pop,
  input  logic [3*COORD_BITS+vsag_pkg::SAMPLE_W-1:0] in_data,
  input  logic                  out_full,
  output logic                  out_push,
  output logic [vsag_pkg::DEST_W+vsag_pkg::SAMPLE_W:0] out_data
);
  import vsag_pkg::*;

  localparam int SW     = $clog2(MAX_SUBDIV + 1);
  localparam int STEP_W = $clog2(COORD_BITS);
  localparam int CW     = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;
  localparam logic [DEST_W-1:0] ADDR_MASK = (ADDR_BITS >= DEST_W) ? {DEST_W{1'b1}} :
                                            DEST_W'((64'd1 << ADDR_BITS) - 64'd1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_CHK, ST_M1, ST_M2, ST_M3, ST_M4
  } state_t;

  state_t                state;
  logic [STEP_W-1:0]     step;
  logic [COORD_BITS-1:0] quo [3];
  logic [SW-1:0]         rem [3];
  logic [FIELD_W-1:0]    lcell [3];
  logic [SAMPLE_W-1:0]   sample;
  logic                  valid;
  logic [DEST_W-1:0]     t1;
  logic [DEST_W-1:0]     t2;
  logic [DEST_W-1:0]     prod;
  logic [2*SW-1:0]       u1;
  logic [2*SW-1:0]       s2;
  logic [3*SW-1:0]       u2;
  logic [3*SW-1:0]       s3;
  logic [3*SW-1:0]       sidx;

  logic [SW-1:0]         s_eff;
  logic [SW:0]           trial [3];
  logic                  take [3];
  logic [CW-1:0]         coarse_x [3];
  logic [CW-1:0]         off_x [3];
  logic [CW-1:0]         diff [3];
  logic                  bad [3];
  logic [DEST_W-1:0]     dest;

  // Effective subdivision: zero acts as one, large values saturate.
  always_comb begin
    if (cfg.subdivision == '0) begin
      s_eff = SW'(1);
    end else if (32'(cfg.subdivision) > MAX_SUBDIV) begin
      s_eff = SW'(MAX_SUBDIV);
    end else begin
      s_eff = SW'(cfg.subdivision);
    end
  end

  // One restoring-division step per axis, quotient shifted in at the bottom.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      trial[a] = {rem[a], quo[a][COORD_BITS-1]};
      take[a]  = (trial[a] >= (SW+1)'(s_eff));
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      coarse_x[a] = CW'(quo[a]);
      off_x[a]    = CW'(field16(cfg.local_offset, 2'(a)));
      diff[a]     = coarse_x[a] - off_x[a];
      bad[a]      = (coarse_x[a] < off_x[a]) ||
                    (diff[a] >= CW'(field16(cfg.local_dims, 2'(a))));
    end
  end

  assign dest     = valid ? ((prod + DEST_W'(sidx)) & ADDR_MASK) : '0;
  assign in_pop   = (state == ST_IDLE) && !in_empty;
  assign out_push = (state == ST_M4) && !out_full;
  assign out_data = {dest, sample, valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!in_empty) begin
            for (int a = 0; a < 3; a++) begin
              quo[a] <= in_data[SAMPLE_W + COORD_BITS*a +: COORD_BITS];
              rem[a] <= '0;
            end
            sample <= in_data[SAMPLE_W-1:0];
            step   <= '0;
            state  <= ST_DIV;
          end
        end
        ST_DIV: begin
          for (int a = 0; a < 3; a++) begin
            rem[a] <= take[a] ? SW'(trial[a] - (SW+1)'(s_eff)) : trial[a][SW-1:0];
            quo[a] <= {quo[a][COORD_BITS-2:0], take[a]};
          end
          if (step == STEP_W'(COORD_BITS - 1)) begin
            step  <= '0;
            state <= ST_CHK;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        ST_CHK: begin
          for (int a = 0; a < 3; a++) begin
            lcell[a] <= diff[a][FIELD_W-1:0];
          end
          valid <= !(bad[0] || bad[1] || bad[2]);
          state <= ST_M1;
        end
        ST_M1: begin
          t1    <= DEST_W'(field16(cfg.local_dims, 2'd1)) * DEST_W'(lcell[2]);
          u1    <= (2*SW)'(s_eff) * (2*SW)'(rem[2]);
          s2    <= (2*SW)'(s_eff) * (2*SW)'(s_eff);
          state <= ST_M2;
        end
        ST_M2: begin
          t2    <= DEST_W'(field16(cfg.local_dims, 2'd0)) * (DEST_W'(lcell[1]) + t1);
          u2    <= (3*SW)'(s_eff) * ((3*SW)'(rem[1]) + (3*SW)'(u1));
          s3    <= (3*SW)'(s2) * (3*SW)'(s_eff);
          state <= ST_M3;
        end
        ST_M3: begin
          prod  <= (DEST_W'(lcell[0]) + t2) * DEST_W'(s3);
          sidx  <= (3*SW)'(rem[0]) + u2;
          state <= ST_M4;
        end
        ST_M4: begin
          if (!out_full) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_step_idle: assert property (@(posedge clk) disable iff (rst)
    (state != ST_DIV) |-> (step == '0)) else $error("division step count left over");
  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    (!rst && in_pop) |=> (state == ST_DIV)) else $error("taken beat did not start division");
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_push && !valid) |-> (out_data[DEST_W+SAMPLE_W:SAMPLE_W+1] == '0))
    else $error("address not zero for an out-of-grid beat");
`endif

endmodule

// ===== design/volume_scatter_address_gen_unit.sv =====
// Volume scatter address generator.
// Input channel: a beat carries one 64-bit sample of a flattened 3D volume and a
// first_of_volume flag; it is taken on a clock edge with push high and full low.
// Result channel: the oldest result sits on dest_address, sample_out and
// write_valid while empty is low; it is taken on an edge with pop high.
// Configuration: cfg_write with cfg_index and cfg_data writes one register in
// the same edge (0 order mode, 1 volume extent, 2 subdivision, 3 local cell
// offset, 4 local grid extent); write only while the block is idle.
// The front keeps the running volume coordinate and hands each sample with its
// coordinate to a two-entry queue. The back divides the coordinate by the
// subdivision with a bit-serial divider (one quotient bit per cycle on all
// three axes) and then forms the address in its multiply stages.
// The back works on one beat at a time: it takes the next beat from the queue
// only after the last one has gone into the result queue.
// Reset returns the coordinate to the origin and the registers to their
// defaults (F order, subdivision one, extents zero) and empties both queues.
// A stalled receiver fills the result queue, then the back waits, then the
// front queue fills and full rises; no beat is lost.
module volume_scatter_address_gen_unit #(
  parameter int COORD_BITS = vsag_pkg::COORD_BITS_DEF,
  parameter int ADDR_BITS  = vsag_pkg::ADDR_BITS_DEF,
  parameter int MAX_SUBDIV = vsag_pkg::MAX_SUBDIV_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [vsag_pkg::SAMPLE_W-1:0] sample_bits,
  input  logic                          first_of_volume,
  output logic                          empty,
  input  logic                          pop,
  output logic [vsag_pkg::DEST_W-1:0]   dest_address,
  output logic [vsag_pkg::SAMPLE_W-1:0] sample_out,
  output logic                          write_valid,
  input  logic                          cfg_write,
  input  logic [vsag_pkg::IDX_W-1:0]    cfg_index,
  input  logic [vsag_pkg::REG_W-1:0]    cfg_data
);
  import vsag_pkg::*;

  localparam int MID_W = 3*COORD_BITS + SAMPLE_W;
  localparam int RES_W = DEST_W + SAMPLE_W + 1;

  cfg_t             cfg;
  logic             mid_push;
  logic [MID_W-1:0] mid_wdata;
  logic             mid_full;
  logic             mid_pop;
  logic [MID_W-1:0] mid_rdata;
  logic             mid_empty;
  logic             res_push;
  logic [RES_W-1:0] res_wdata;
  logic             res_full;
  logic [RES_W-1:0] res_rdata;

  // Configuration registers; indexes past the last register are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.order_mode   <= 1'b1;
      cfg.volume_dims  <= '0;
      cfg.subdivision  <= SUBDIV_W'(1);
      cfg.local_offset <= '0;
      cfg.local_dims   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ORDER_MODE:   cfg.order_mode   <= cfg_data[0];
        REG_VOLUME_DIMS:  cfg.volume_dims  <= cfg_data;
        REG_SUBDIVISION:  cfg.subdivision  <= cfg_data[SUBDIV_W-1:0];
        REG_LOCAL_OFFSET: cfg.local_offset <= cfg_data;
        REG_LOCAL_DIMS:   cfg.local_dims   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  vsag_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .push            (push),
    .full            (full),
    .sample_bits     (sample_bits),
    .first_of_volume (first_of_volume),
    .q_push          (mid_push),
    .q_data          (mid_wdata),
    .q_full          (mid_full)
  );

  // Queue between the coordinate front and the address back.
  vsag_fifo #(
    .W (MID_W)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr      (mid_push),
    .wr_data (mid_wdata),
    .full    (mid_full),
    .rd      (mid_pop),
    .rd_data (mid_rdata),
    .empty   (mid_empty)
  );

  vsag_back #(
    .COORD_BITS (COORD_BITS),
    .ADDR_BITS  (ADDR_BITS),
    .MAX_SUBDIV (MAX_SUBDIV)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_empty (mid_empty),
    .in_pop   (mid_pop),
    .in_data  (mid_rdata),
    .out_full (res_full),
    .out_push (res_push),
    .out_data (res_wdata)
  );

  // Result queue decouples the back from a stalled receiver.
  vsag_fifo #(
    .W (RES_W)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr      (res_push),
    .wr_data (res_wdata),
    .full    (res_full),
    .rd      (pop),
    .rd_data (res_rdata),
    .empty   (empty)
  );

  assign dest_address = res_rdata[RES_W-1 -: DEST_W];
  assign sample_out   = res_rdata[SAMPLE_W:1];
  assign write_valid  = res_rdata[0];

endmodule

// ===== sim/volume_scatter_address_gen_unit_tb.sv =====
module volume_scatter_address_gen_unit_tb;
  import vsag_pkg::*;

  // The block is used at its default parameters.
  localparam int COORD_W = COORD_BITS_DEF;
  localparam int ADDR_W  = ADDR_BITS_DEF;
  localparam int SUB_MAX = MAX_SUBDIV_DEF;

  localparam logic [63:0] COORD_MASK = (64'd1 << COORD_W) - 64'd1;
  localparam logic [63:0] ADDR_MASK  = (64'd1 << ADDR_W) - 64'd1;

  // Run shape. Even the slowest legal run stays far below the cycle limit.
  localparam int PHASES         = 16;
  localparam int PHASE_BEATS    = 34;
  localparam int BURST_BEATS    = 40;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 40;
  localparam int CYCLE_LIMIT    = 300000;
  localparam int IDLE_HEAVY     = 83;
  localparam int IDLE_LIGHT     = 30;
  localparam int REPORT_LIMIT   = 10;

  // One beat on the input side and one on the result side.
  typedef struct packed {
    logic [SAMPLE_W-1:0] bits;
    logic                first;
  } sample_item_t;

  typedef struct packed {
    logic [DEST_W-1:0]   dest;
    logic [SAMPLE_W-1:0] bits;
    logic                wv;
  } remap_beat_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  logic [SAMPLE_W-1:0] sample_bits = '0;
  logic                first_of_volume = 1'b0;
  logic                empty;
  logic                pop = 1'b0;
  logic [DEST_W-1:0]   dest_address;
  logic [SAMPLE_W-1:0] sample_out;
  logic                write_valid;
  logic                cfg_write = 1'b0;
  logic [IDX_W-1:0]    cfg_index = REG_ORDER_MODE;
  logic [REG_W-1:0]    cfg_data = '0;

  // Samples waiting to be offered, and remapped beats waiting to come out.
  sample_item_t sample_backlog[$];
  remap_beat_t  due_beats[$];

  // Our own copy of the register file and of the running volume coordinate.
  cfg_t             shadow_cfg;
  logic [COORD_W-1:0] next_pos [0:2];

  // Idle rates of both sides in percent, set between phases.
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;

  // Long receiver hold-off: a one-cycle request loads the countdown.
  logic rx_hold_req = 1'b0;
  int   rx_hold_left = 0;

  int cycle_count = 0;
  int mismatches = 0;
  int beats_in = 0;
  int beats_out = 0;
  int inside_count = 0;
  int outside_count = 0;
  int restarts = 0;
  int full_stalls = 0;
  int settings = 0;

  volume_scatter_address_gen_unit uut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .sample_bits     (sample_bits),
    .first_of_volume (first_of_volume),
    .empty           (empty),
    .pop             (pop),
    .dest_address    (dest_address),
    .sample_out      (sample_out),
    .write_valid     (write_valid),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Packs three 16-bit components, x in the low bits.
  function automatic logic [REG_W-1:0] xyz(input logic [FIELD_W-1:0] x,
                                           input logic [FIELD_W-1:0] y,
                                           input logic [FIELD_W-1:0] z);
    return {z, y, x};
  endfunction

  // A random register component: mostly in [lo, hi], now and then zero or
  // the largest value.
  function automatic logic [FIELD_W-1:0] pick_field(input int lo, input int hi);
    logic [31:0] r;
    r = $urandom_range(11, 0);
    if (r == 0) r = 0;
    else if (r == 1) r = 32'hFFFF;
    else r = $urandom_range(hi, lo);
    return r[FIELD_W-1:0];
  endfunction

  // Works out the remapped beat for one accepted sample and advances the
  // running coordinate, exactly as the block is specified to.
  function automatic remap_beat_t remap_sample(input sample_item_t it);
    logic [63:0] pos [0:2];
    logic [63:0] lcell [0:2];
    logic [63:0] subc [0:2];
    logic [63:0] s;
    logic [63:0] coarse;
    logic [63:0] off;
    logic [63:0] span;
    logic [63:0] li;
    logic [63:0] lj;
    logic [63:0] cidx;
    logic [63:0] sidx;
    logic [63:0] addr;
    logic [63:0] nxt;
    logic        in_grid;
    logic        carry;
    int          ax;
    remap_beat_t r;

    // A subdivision of zero behaves as one; anything above the maximum is
    // clamped to it.
    s = 64'(shadow_cfg.subdivision);
    if (s == 64'd0) s = 64'd1;
    if (s > 64'(SUB_MAX)) s = 64'(SUB_MAX);

    in_grid = 1'b1;
    for (int a = 0; a < 3; a++) begin
      pos[a] = it.first ? 64'd0 : {{(64-COORD_W){1'b0}}, next_pos[a]};
      coarse = pos[a] / s;
      subc[a] = pos[a] % s;
      off = 64'(shadow_cfg.local_offset[FIELD_W*a +: FIELD_W]);
      span = 64'(shadow_cfg.local_dims[FIELD_W*a +: FIELD_W]);
      if (coarse < off || coarse - off >= span) begin
        in_grid = 1'b0;
        lcell[a] = 64'd0;
      end else begin
        lcell[a] = coarse - off;
      end
    end

    // Outside the local grid the address reads as zero.
    addr = 64'd0;
    if (in_grid) begin
      li = 64'(shadow_cfg.local_dims[FIELD_W*0 +: FIELD_W]);
      lj = 64'(shadow_cfg.local_dims[FIELD_W*1 +: FIELD_W]);
      cidx = lcell[0] + li * (lcell[1] + lj * lcell[2]);
      sidx = subc[0] + s * (subc[1] + s * subc[2]);
      addr = (cidx * (s * s * s) + sidx) & ADDR_MASK;
    end
    r.dest = addr[DEST_W-1:0];
    r.bits = it.bits;
    r.wv = in_grid;

    // F order steps x first, C order steps z first. An axis that reaches its
    // extent (zero included) or overflows wraps and carries onward.
    carry = 1'b1;
    for (int k = 0; k < 3; k++) begin
      ax = shadow_cfg.order_mode ? k : 2 - k;
      if (carry) begin
        span = 64'(shadow_cfg.volume_dims[FIELD_W*ax +: FIELD_W]);
        nxt = (pos[ax] + 64'd1) & COORD_MASK;
        if (nxt == 64'd0 || nxt >= span) begin
          pos[ax] = 64'd0;
        end else begin
          pos[ax] = nxt;
          carry = 1'b0;
        end
      end
    end
    for (int a = 0; a < 3; a++) next_pos[a] = pos[a][COORD_W-1:0];
    return r;
  endfunction

  // Input driver. A beat is taken on an edge with push high and full low;
  // the expectation is formed right there. A beat that is stalled by full is
  // held as it is, otherwise the next backlog entry goes out unless the
  // sender picks an idle cycle.
  always @(posedge clk) begin : drive_samples
    sample_item_t it;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        it = sample_backlog.pop_front();
        due_beats.push_back(remap_sample(it));
        beats_in++;
        if (it.first) restarts++;
      end
      if (push && full) begin
        full_stalls++;
      end else if (sample_backlog.size() != 0 &&
                   !(tx_idle_pct != 0 && $urandom_range(99, 0) < tx_idle_pct)) begin
        push <= 1'b1;
        sample_bits <= sample_backlog[0].bits;
        first_of_volume <= sample_backlog[0].first;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Countdown for the long receiver hold-off.
  always @(posedge clk) begin : hold_off_counter
    if (rst) begin
      rx_hold_left <= 0;
    end else if (rx_hold_req) begin
      rx_hold_left <= RX_HOLD_CYCLES;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // Result monitor. Every beat taken from the block is compared field by
  // field against the oldest expectation.
  always @(posedge clk) begin : check_results
    remap_beat_t got;
    remap_beat_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got.dest = dest_address;
        got.bits = sample_out;
        got.wv = write_valid;
        beats_out++;
        if (got.wv) inside_count++;
        else outside_count++;
        if (due_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("result beat %0d arrived with nothing expected: dest %h sample %h wv %b",
                     beats_out, got.dest, got.bits, got.wv);
        end else begin
          want = due_beats.pop_front();
          if (got.dest !== want.dest || got.bits !== want.bits || got.wv !== want.wv) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("mismatch on result beat %0d: dest %h/%h sample %h/%h wv %b/%b (exp/act)",
                       beats_out, want.dest, got.dest, want.bits, got.bits, want.wv, got.wv);
          end
        end
      end
      pop <= (rx_hold_left == 0) &&
             !(rx_stall_pct != 0 && $urandom_range(99, 0) < rx_stall_pct);
    end
  end

  // Ends a run that hangs.
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic offer_sample(input logic [SAMPLE_W-1:0] bits, input logic first);
    sample_item_t it;
    it.bits = bits;
    it.first = first;
    sample_backlog.push_back(it);
  endtask

  // Waits until every queued sample went in and every result came out.
  task automatic settle();
    while (sample_backlog.size() != 0 || push || due_beats.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // One register write per edge; the shadow copy follows the same masking as
  // the hardware.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_ORDER_MODE:   shadow_cfg.order_mode = data[0];
      REG_VOLUME_DIMS:  shadow_cfg.volume_dims = data;
      REG_SUBDIVISION:  shadow_cfg.subdivision = data[SUBDIV_W-1:0];
      REG_LOCAL_OFFSET: shadow_cfg.local_offset = data;
      REG_LOCAL_DIMS:   shadow_cfg.local_dims = data;
      default: ;
    endcase
  endtask

  task automatic set_registers(input cfg_t c);
    write_reg(REG_ORDER_MODE, {{(REG_W-1){1'b0}}, c.order_mode});
    write_reg(REG_VOLUME_DIMS, c.volume_dims);
    write_reg(REG_SUBDIVISION, {{(REG_W-SUBDIV_W){1'b0}}, c.subdivision});
    write_reg(REG_LOCAL_OFFSET, c.local_offset);
    write_reg(REG_LOCAL_DIMS, c.local_dims);
    @(posedge clk);
    cfg_write <= 1'b0;
    settings++;
  endtask

  initial begin : stimulus
    cfg_t        setting;
    logic [31:0] rnd;
    longint      vol_len;
    longint      ext;
    int          queued;
    int          n;
    bit          paused;

    // Register reset values and the origin as the first coordinate.
    shadow_cfg.order_mode = 1'b1;
    shadow_cfg.volume_dims = '0;
    shadow_cfg.subdivision = 5'd1;
    shadow_cfg.local_offset = '0;
    shadow_cfg.local_dims = '0;
    for (int a = 0; a < 3; a++) next_pos[a] = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Straight out of reset the local grid is empty, so nothing is inside.
    offer_sample(64'h0, 1'b0);
    offer_sample({SAMPLE_W{1'b1}}, 1'b1);
    settle();

    // A small C-order volume, 2x3x2, in cells of two with the grid shifted by
    // one along y: only the beats with y of two land inside. The thirteenth beat follows the
    // wrap at the end of the volume.
    setting.order_mode = 1'b0;
    setting.volume_dims = xyz(16'd2, 16'd3, 16'd2);
    setting.subdivision = 5'd2;
    setting.local_offset = xyz(16'd0, 16'd1, 16'd0);
    setting.local_dims = xyz(16'd1, 16'd1, 16'd1);
    set_registers(setting);
    for (int i = 0; i < 13; i++)
      offer_sample((i % 2) ? 64'h5555_5555_5555_5555 : 64'hAAAA_AAAA_AAAA_AAAA, i == 0);
    settle();

    // F order with x and y of extent one, so z steps on every beat. A
    // subdivision of zero acts as one, and the full-size local grid makes the
    // address wrap once z reaches two.
    setting.order_mode = 1'b1;
    setting.volume_dims = xyz(16'd1, 16'd1, 16'd5);
    setting.subdivision = 5'd0;
    setting.local_offset = '0;
    setting.local_dims = '1;
    set_registers(setting);
    for (int i = 0; i < 4; i++) offer_sample(64'd1 << (i * 16 + 3), i == 0);
    settle();

    // Oversized subdivision clamps to the maximum; the volume shrinks under
    // the running coordinate, which must wrap on the next step.
    write_reg(REG_SUBDIVISION, 48'd31);
    write_reg(REG_VOLUME_DIMS, xyz(16'd1, 16'd1, 16'd2));
    @(posedge clk);
    cfg_write <= 1'b0;
    offer_sample(64'hFFFF_0000_FFFF_0000, 1'b0);
    offer_sample(64'h0000_FFFF_0000_FFFF, 1'b0);
    settle();

    // Zero extents on y and z: every wrap of x carries straight through.
    setting.order_mode = 1'b1;
    setting.volume_dims = xyz(16'd3, 16'd0, 16'd0);
    setting.subdivision = 5'd1;
    setting.local_offset = '0;
    setting.local_dims = xyz(16'd2, 16'd1, 16'd1);
    set_registers(setting);
    for (int i = 0; i < 3; i++) offer_sample({$urandom, $urandom}, i == 0);
    settle();

    // Random phases. Most beats form runs of at most one volume that start with a
    // restart flag; the rest are short bursts with restarts at random. Each phase
    // pauses the sender once in the middle until the block has drained.
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
        1: begin tx_idle_pct = IDLE_HEAVY; rx_stall_pct = 0; end
        2: begin tx_idle_pct = 0; rx_stall_pct = IDLE_HEAVY; end
        default: begin tx_idle_pct = IDLE_LIGHT; rx_stall_pct = IDLE_LIGHT; end
      endcase

      if (p == PHASES - 1) begin
        // Extreme setting: extents and local offset at their largest value, subdivision at the maximum.
        rnd = $urandom_range(1, 0);
        setting.order_mode = rnd[0];
        setting.volume_dims = '1;
        setting.subdivision = SUBDIV_W'(SUB_MAX);
        setting.local_offset = '1;
        setting.local_dims = '1;
      end else begin
        rnd = $urandom_range(1, 0);
        setting.order_mode = rnd[0];
        setting.volume_dims = xyz(pick_field(1, 9), pick_field(1, 9), pick_field(1, 9));
        rnd = ($urandom_range(9, 0) < 7) ? $urandom_range(4, 1) : $urandom_range(31, 0);
        setting.subdivision = rnd[SUBDIV_W-1:0];
        setting.local_offset = xyz(pick_field(0, 2), pick_field(0, 2), pick_field(0, 2));
        setting.local_dims = xyz(pick_field(1, 6), pick_field(1, 6), pick_field(1, 6));
      end
      set_registers(setting);

      queued = 0;
      paused = 1'b0;
      while (queued < PHASE_BEATS) begin
        if (!paused && queued >= PHASE_BEATS / 2) begin
          settle();
          paused = 1'b1;
        end
        if ($urandom_range(9, 0) == 0) begin
          n = $urandom_range(5, 1);
          repeat (n) offer_sample({$urandom, $urandom}, $urandom_range(3, 0) == 0);
        end else begin
          vol_len = 1;
          for (int a = 0; a < 3; a++) begin
            ext = longint'(64'(shadow_cfg.volume_dims[FIELD_W*a +: FIELD_W]));
            vol_len = vol_len * ((ext == 0) ? 1 : ext);
          end
          if (vol_len > 64) vol_len = longint'($urandom_range(48, 8));
          else if ($urandom_range(2, 0) == 0)
            vol_len = longint'($urandom_range(int'(vol_len), 1));
          n = int'(vol_len);
          for (int i = 0; i < n; i++) offer_sample({$urandom, $urandom}, i == 0);
        end
        queued += n;
      end
      settle();

      // Once, early on: the receiver holds off for a long stretch while the
      // sender keeps offering, so the block fills up and raises full.
      if (p == 2) begin
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        @(posedge clk);
        rx_hold_req <= 1'b1;
        @(posedge clk);
        rx_hold_req <= 1'b0;
        for (int i = 0; i < BURST_BEATS; i++) offer_sample({$urandom, $urandom}, i == 0);
        settle();
      end
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (due_beats.size() != 0)
      $display("%0d expected result beats never came out", due_beats.size());

    $display("covered %0d samples over %0d register settings: %0d inside the grid, %0d outside",
             beats_in, settings, inside_count, outside_count);
    $display("%0d volume restarts, input held by full for %0d cycles, %0d mismatches",
             restarts, full_stalls, mismatches);
    if (mismatches == 0 && due_beats.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
